// ===== rtl/core/gac_pkg.sv =====
// ----------------------------------------------------------------------------
// gac_pkg
// Shared types, constants and helpers for the gamepad axis conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package gac_pkg;

    // stick and threshold limits
    localparam int unsigned STICK_W     = 8;
    localparam int signed   DIR_THRESH  = 64;
    localparam logic [6:0]  DZ_RESET    = 7'd19;
    localparam logic [6:0]  DZ_MAX      = 7'd126;
    localparam logic [6:0]  DZ_FULL     = 7'd127;
    localparam logic [7:0]  EXTRA_LOW   = 8'd64;
    localparam logic [7:0]  EXTRA_HIGH  = 8'd192;

    // hat thresholds in hundredths of degrees (whole-degree bounds times 100)
    localparam logic [15:0] HAT_CENTERED = 16'hFFFF;
    localparam logic [15:0] HAT_UP_HI    = 16'd33800;
    localparam logic [15:0] HAT_UP_LO    = 16'd2300;
    localparam logic [15:0] HAT_UR       = 16'd6800;
    localparam logic [15:0] HAT_R        = 16'd11300;
    localparam logic [15:0] HAT_DR       = 16'd15800;
    localparam logic [15:0] HAT_D        = 16'd20300;
    localparam logic [15:0] HAT_DL       = 16'd24800;
    localparam logic [15:0] HAT_L        = 16'd29300;
    localparam logic [8:0]  HAT_POS      = 9'h080;
    localparam logic [8:0]  HAT_NEG      = 9'h180;

    // arithmetic widths
    localparam int unsigned ROOT_W = 18;
    localparam int unsigned SREM_W = 20;
    localparam int unsigned NUM_W  = 33;
    localparam int unsigned DEN_W  = 26;
    localparam int unsigned QUO_W  = 9;

    // pipeline layout
    localparam int unsigned SQ_STAGES  = 9;
    localparam int unsigned DIV_STAGES = QUO_W;
    localparam int unsigned ST_PRE     = 0;
    localparam int unsigned ST_SUM     = 1;
    localparam int unsigned ST_SQ0     = 2;
    localparam int unsigned ST_OVER    = ST_SQ0 + SQ_STAGES;
    localparam int unsigned ST_NUM     = ST_OVER + 1;
    localparam int unsigned ST_DIV0    = ST_NUM + 1;
    localparam int unsigned ST_OUT     = ST_DIV0 + DIV_STAGES;
    localparam int unsigned NSTAGES    = ST_OUT + 1;

    // fields that ride along with the arithmetic
    typedef struct packed {
        logic signed [7:0] x;
        logic signed [7:0] y;
        logic [6:0]        rad;
        logic              bypass;
        logic              in_dz;
        logic [8:0]        hat_x;
        logic [8:0]        hat_y;
        logic [3:0]        hat_dirs;
        logic [7:0]        extra_pos;
        logic [1:0]        extra_dirs;
    } t_side;

    // saturate a 16-bit signed reading to -128..127
    function automatic logic signed [7:0] clamp_s8(input logic signed [15:0] v);
        logic signed [7:0] res;
        if (v < -16'sd128) begin
            res = -8'sd128;
        end else if (v > 16'sd127) begin
            res = 8'sd127;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gac_sqrt_step.sv =====
// ----------------------------------------------------------------------------
// gac_sqrt_step
// Two digit-by-digit square root iterations, one radicand bit pair each.
// ----------------------------------------------------------------------------
`default_nettype none

module gac_sqrt_step (
    input  wire logic [gac_pkg::SREM_W-1:0] i_rem,
    input  wire logic [gac_pkg::ROOT_W-1:0] i_root,
    input  wire logic [3:0]                 i_bits,
    output      logic [gac_pkg::SREM_W-1:0] o_rem,
    output      logic [gac_pkg::ROOT_W-1:0] o_root
);
    import gac_pkg::*;

    logic [SREM_W:0]   w_r1, w_r2;
    logic [SREM_W:0]   w_t1, w_t2;
    logic [SREM_W-1:0] w_rem1;
    logic [ROOT_W-1:0] w_root1;

    // remainder bits that survive the shift by two
    function automatic logic [SREM_W-2:0] w_rem_hi(input logic [SREM_W-1:0] r);
        return r[SREM_W-2:0];
    endfunction

    // first iteration, upper bit pair
    always_comb begin
        w_r1 = {w_rem_hi(i_rem), i_bits[3:2]};
        w_t1 = {1'b0, i_root, 2'b01};
        if (w_r1 >= w_t1) begin
            w_rem1  = SREM_W'(w_r1 - w_t1);
            w_root1 = {i_root[ROOT_W-2:0], 1'b1};
        end else begin
            w_rem1  = SREM_W'(w_r1);
            w_root1 = {i_root[ROOT_W-2:0], 1'b0};
        end
    end

    // second iteration, lower bit pair
    always_comb begin
        w_r2 = {w_rem_hi(w_rem1), i_bits[1:0]};
        w_t2 = {1'b0, w_root1, 2'b01};
        if (w_r2 >= w_t2) begin
            o_rem  = SREM_W'(w_r2 - w_t2);
            o_root = {w_root1[ROOT_W-2:0], 1'b1};
        end else begin
            o_rem  = SREM_W'(w_r2);
            o_root = {w_root1[ROOT_W-2:0], 1'b0};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gac_div_step.sv =====
// ----------------------------------------------------------------------------
// gac_div_step
// One restoring division step: tries the shifted divisor, yields one bit.
// ----------------------------------------------------------------------------
`default_nettype none

module gac_div_step #(
    parameter int unsigned SHIFT = 0
) (
    input  wire logic [gac_pkg::NUM_W-1:0] i_rem,
    input  wire logic [gac_pkg::DEN_W-1:0] i_den,
    output      logic [gac_pkg::NUM_W-1:0] o_rem,
    output      logic                      o_bit
);
    import gac_pkg::*;

    localparam int unsigned CMP_W = DEN_W + QUO_W;

    logic [CMP_W-1:0] w_dsh;
    logic [CMP_W-1:0] w_rem;

    // compare remainder against divisor scaled by this quotient bit
    always_comb begin
        w_dsh = CMP_W'(i_den) << SHIFT;
        w_rem = CMP_W'(i_rem);
        if (w_rem >= w_dsh) begin
            o_rem = NUM_W'(w_rem - w_dsh);
            o_bit = 1'b1;
        end else begin
            o_rem = i_rem;
            o_bit = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gamepad_axis_conditioner_top.sv =====
// ----------------------------------------------------------------------------
// gamepad_axis_conditioner_top
// Clamps stick, hat and extra axis readings and applies a radial deadzone
// with rescale to the stick, one sample per beat.
//
// channel   dir  bits  contents
// s_axis    in   64    raw_x, raw_y, raw_hat, raw_extra
// m_axis    out  56    stick_x, stick_y, stick_dirs, hat_x, hat_y, hat_dirs,
//                      extra_pos, extra_dirs
// cfg       in   7     deadzone_radius
//
// 23 register stages: prep, sum, 9 square root stages (two root bits each),
// rescale setup, numerator, 9 division stages (one quotient bit each), output.
// A new beat enters every cycle unless a full pipeline is held by the output.
// Each stage moves when the next one is empty or moving, so bubbles collapse
// and the input keeps taking beats while the output waits, until all are full.
// Synchronous active-low reset clears valid bits and sets the radius to 19.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_axis_conditioner_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [6:0]  i_cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // raw_x[15:0], raw_y[31:16], raw_hat[47:32], raw_extra[63:48]
    input  wire logic [63:0] s_axis_tdata,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // stick_x[7:0], stick_y[15:8], stick_dirs[19:16], hat_x[28:20],
    // hat_y[37:29], hat_dirs[41:38], extra_pos[49:42], extra_dirs[51:50]
    output      logic [55:0] m_axis_tdata
);
    import gac_pkg::*;

    logic [6:0]        r_rad;
    logic [NSTAGES-1:0] r_v;
    logic [NSTAGES:0]  en;
    t_side             r_side [NSTAGES];

    // stage work registers
    logic [14:0]       r_xx, r_yy;
    logic [15:0]       r_s    [SQ_STAGES+1];
    logic [SREM_W-1:0] r_srem [SQ_STAGES+1];
    logic [ROOT_W-1:0] r_root [SQ_STAGES+1];
    logic [16:0]       r_over;
    logic [24:0]       r_den25;
    logic [14:0]       r_m127x, r_m127y;
    logic [NUM_W-1:0]  r_drem_x [DIV_STAGES+1];
    logic [NUM_W-1:0]  r_drem_y [DIV_STAGES+1];
    logic [DEN_W-1:0]  r_dden   [DIV_STAGES+1];
    logic [QUO_W-1:0]  r_qx     [DIV_STAGES+1];
    logic [QUO_W-1:0]  r_qy     [DIV_STAGES+1];
    logic [7:0]        r_ox, r_oy;
    logic [3:0]        r_sdirs;

    // radius register, saturated at 126
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad <= DZ_RESET;
        end else if (i_cfg_wr_en) begin
            r_rad <= (i_cfg_wr_data == DZ_FULL) ? DZ_MAX : i_cfg_wr_data;
        end
    end

    // stage enables: move when empty or when the next stage moves
    always_comb begin
        en[NSTAGES] = m_axis_tready;
        for (int k = NSTAGES - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTAGES; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // prep: clamp, hat decode, extra axis, squares
    logic signed [7:0]  w_x, w_y;
    logic [15:0]        w_hat;
    logic signed [15:0] w_ex16;
    logic [7:0]         w_ex;
    logic [8:0]         w_hx, w_hy;
    t_side              w_side0;

    always_comb begin
        w_x    = clamp_s8(s_axis_tdata[15:0]);
        w_y    = clamp_s8(s_axis_tdata[31:16]);
        w_hat  = s_axis_tdata[47:32];
        w_ex16 = s_axis_tdata[63:48];
        if (w_ex16 < 16'sd0) begin
            w_ex = 8'd0;
        end else if (w_ex16 > 16'sd255) begin
            w_ex = 8'd255;
        end else begin
            w_ex = w_ex16[7:0];
        end
        w_hx = 9'd0;
        w_hy = 9'd0;
        if (w_hat != HAT_CENTERED) begin
            if (w_hat >= HAT_UP_HI || w_hat < HAT_UP_LO) begin
                w_hy = HAT_NEG;
            end else if (w_hat < HAT_UR) begin
                w_hy = HAT_NEG;
                w_hx = HAT_POS;
            end else if (w_hat < HAT_R) begin
                w_hx = HAT_POS;
            end else if (w_hat < HAT_DR) begin
                w_hy = HAT_POS;
                w_hx = HAT_POS;
            end else if (w_hat < HAT_D) begin
                w_hy = HAT_POS;
            end else if (w_hat < HAT_DL) begin
                w_hy = HAT_POS;
                w_hx = HAT_NEG;
            end else if (w_hat < HAT_L) begin
                w_hx = HAT_NEG;
            end else begin
                w_hy = HAT_NEG;
                w_hx = HAT_NEG;
            end
        end
        w_side0.x          = w_x;
        w_side0.y          = w_y;
        w_side0.rad        = r_rad;
        w_side0.bypass     = (r_rad == 7'd0);
        w_side0.in_dz      = 1'b0;
        w_side0.hat_x      = w_hx;
        w_side0.hat_y      = w_hy;
        w_side0.hat_dirs   = {w_hy == HAT_POS, w_hy == HAT_NEG,
                              w_hx == HAT_POS, w_hx == HAT_NEG};
        w_side0.extra_pos  = w_ex;
        w_side0.extra_dirs = {w_ex > EXTRA_HIGH, w_ex < EXTRA_LOW};
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_PRE]) begin
            r_xx <= 15'(unsigned'(16'(w_x * w_x)));
            r_yy <= 15'(unsigned'(16'(w_y * w_y)));
        end
    end

    // sum of squares and deadzone test; this also seeds the root
    logic [15:0] w_s;
    logic [13:0] w_rr;
    t_side       w_side1;
    assign w_s  = 16'(r_xx) + 16'(r_yy);
    assign w_rr = 14'(r_side[ST_PRE].rad * r_side[ST_PRE].rad);

    always_comb begin
        w_side1       = r_side[ST_PRE];
        w_side1.in_dz = (w_s <= 16'(w_rr));
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_SUM]) begin
            r_s[0]    <= w_s;
            r_srem[0] <= '0;
            r_root[0] <= '0;
        end
    end

    // side fields ride along
    always_ff @(posedge i_clk) begin
        if (en[ST_PRE]) begin
            r_side[ST_PRE] <= w_side0;
        end
        if (en[ST_SUM]) begin
            r_side[ST_SUM] <= w_side1;
        end
        for (int k = ST_SUM + 1; k < NSTAGES; k++) begin
            if (en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // square root of s shifted by 20, two root bits a stage
    for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sqrt
        logic [3:0]        w_bits;
        logic [SREM_W-1:0] w_rem;
        logic [ROOT_W-1:0] w_root;

        if (i < 4) begin : g_hi
            assign w_bits = r_s[i][15-4*i -: 4];
        end else begin : g_lo
            assign w_bits = 4'd0;
        end

        gac_sqrt_step u_step (
            .i_rem  (r_srem[i]),
            .i_root (r_root[i]),
            .i_bits (w_bits),
            .o_rem  (w_rem),
            .o_root (w_root)
        );

        always_ff @(posedge i_clk) begin
            if (en[ST_SQ0+i]) begin
                r_s[i+1]    <= r_s[i];
                r_srem[i+1] <= w_rem;
                r_root[i+1] <= w_root;
            end
        end
    end

    // rescale setup: capped excess, denominator, magnitudes times 127
    t_side       w_sq_side;
    logic [17:0] w_m;
    logic [6:0]  w_span;
    logic [17:0] w_ex_over;
    logic [16:0] w_cap;
    logic [7:0]  w_magx, w_magy;

    always_comb begin
        w_sq_side = r_side[ST_OVER-1];
        w_m       = r_root[SQ_STAGES];
        w_span    = DZ_FULL - w_sq_side.rad;
        w_ex_over = w_m - {1'b0, w_sq_side.rad, 10'd0};
        w_cap     = {w_span, 10'd0};
        w_magx    = w_sq_side.x[7] ? 8'(-w_sq_side.x) : 8'(w_sq_side.x);
        w_magy    = w_sq_side.y[7] ? 8'(-w_sq_side.y) : 8'(w_sq_side.y);
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_OVER]) begin
            r_over  <= (w_ex_over > 18'(w_cap)) ? w_cap : w_ex_over[16:0];
            r_den25 <= 25'(w_m * w_span);
            r_m127x <= 15'(w_magx * 7'd127);
            r_m127y <= 15'(w_magy * 7'd127);
        end
    end

    // numerators with the rounding term, doubled denominator
    logic [31:0] w_numx, w_numy;
    assign w_numx = 32'(r_m127x * r_over);
    assign w_numy = 32'(r_m127y * r_over);

    always_ff @(posedge i_clk) begin
        if (en[ST_NUM]) begin
            r_drem_x[0] <= {w_numx, 1'b0} + NUM_W'(r_den25);
            r_drem_y[0] <= {w_numy, 1'b0} + NUM_W'(r_den25);
            r_dden[0]   <= {r_den25, 1'b0};
            r_qx[0]     <= '0;
            r_qy[0]     <= '0;
        end
    end

    // restoring division, one quotient bit a stage for both axes
    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
        logic [NUM_W-1:0] w_rx, w_ry;
        logic             w_bx, w_by;

        gac_div_step #(.SHIFT(DIV_STAGES - 1 - i)) u_dx (
            .i_rem (r_drem_x[i]),
            .i_den (r_dden[i]),
            .o_rem (w_rx),
            .o_bit (w_bx)
        );

        gac_div_step #(.SHIFT(DIV_STAGES - 1 - i)) u_dy (
            .i_rem (r_drem_y[i]),
            .i_den (r_dden[i]),
            .o_rem (w_ry),
            .o_bit (w_by)
        );

        always_ff @(posedge i_clk) begin
            if (en[ST_DIV0+i]) begin
                r_drem_x[i+1] <= w_rx;
                r_drem_y[i+1] <= w_ry;
                r_dden[i+1]   <= r_dden[i];
                r_qx[i+1]     <= {r_qx[i][QUO_W-2:0], w_bx};
                r_qy[i+1]     <= {r_qy[i][QUO_W-2:0], w_by};
            end
        end
    end

    // output: sign restore, clamp, select, direction flags
    t_side             w_dv_side;
    logic signed [7:0] w_fx, w_fy;

    function automatic logic signed [7:0] signed_sat(input logic neg,
                                                     input logic [QUO_W-1:0] q);
        logic signed [7:0] res;
        if (neg) begin
            res = (q > QUO_W'(128)) ? -8'sd128 : 8'(-q);
        end else begin
            res = (q > QUO_W'(127)) ? 8'sd127 : 8'(q);
        end
        return res;
    endfunction

    always_comb begin
        w_dv_side = r_side[ST_OUT-1];
        if (w_dv_side.bypass) begin
            w_fx = w_dv_side.x;
            w_fy = w_dv_side.y;
        end else if (w_dv_side.in_dz) begin
            w_fx = 8'sd0;
            w_fy = 8'sd0;
        end else begin
            w_fx = signed_sat(w_dv_side.x[7], r_qx[DIV_STAGES]);
            w_fy = signed_sat(w_dv_side.y[7], r_qy[DIV_STAGES]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[ST_OUT]) begin
            r_ox    <= w_fx;
            r_oy    <= w_fy;
            r_sdirs <= {w_fy > signed'(8'(DIR_THRESH)), w_fy < -signed'(8'(DIR_THRESH)),
                        w_fx > signed'(8'(DIR_THRESH)), w_fx < -signed'(8'(DIR_THRESH))};
        end
    end

    assign m_axis_tvalid = r_v[ST_OUT];
    assign m_axis_tdata  = {4'd0,
                            r_side[ST_OUT].extra_dirs,
                            r_side[ST_OUT].extra_pos,
                            r_side[ST_OUT].hat_dirs,
                            r_side[ST_OUT].hat_y,
                            r_side[ST_OUT].hat_x,
                            r_sdirs, r_oy, r_ox};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gamepad axis conditioner. Raw samples stream in
// with random bursts and gaps while the output side stalls on its own pattern.
// Each accepted sample is run through a local model of the deadzone, hat and
// extra axis logic, and each output beat is checked field by field, in order.
// The deadzone radius is changed between phases while the block is drained.
// ----------------------------------------------------------------------------
`default_nettype none

// expected output store and sample predictor
class cond_scoreboard;
    logic [55:0] expected_q[$];
    int          mismatches;

    // integer square root, truncated
    static function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    static function int sat_range(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // scale one axis by the ramp beyond the deadzone, rounded half away from zero
    static function int rescale(int v, longint unsigned mag_fx, int unsigned rad);
        longint unsigned span, over, cap, mag, num, den, q;
        int res;
        span = 127 - rad;
        over = mag_fx - longint'(rad) * 1024;
        cap  = span * 1024;
        mag  = (v < 0) ? -v : v;
        if (over > cap) over = cap;
        num = mag * 127 * over;
        den = mag_fx * span;
        q   = (2 * num + den) / (2 * den);
        res = int'(q);
        if (v < 0) res = -res;
        return sat_range(res, -128, 127);
    endfunction

    static function logic [55:0] condition(logic [63:0] raw, int unsigned rad);
        int x, y, ex, px, py, nx, ny;
        int unsigned deg;
        logic [15:0] hat;
        longint unsigned ssum, mag_fx;
        logic [3:0] sdirs, hdirs;
        logic [1:0] edirs;
        logic [8:0] hx, hy;
        x   = sat_range(int'($signed(raw[15:0])), -128, 127);
        y   = sat_range(int'($signed(raw[31:16])), -128, 127);
        hat = raw[47:32];
        ex  = sat_range(int'($signed(raw[63:48])), 0, 255);
        px  = 0;
        py  = 0;
        sdirs = '0;
        hdirs = '0;
        edirs = '0;
        // radial deadzone
        if (rad != 0) begin
            ssum = x * x + y * y;
            if (ssum <= longint'(rad) * rad) begin
                x = 0;
                y = 0;
            end else begin
                mag_fx = int_sqrt(ssum << 20);
                nx = rescale(x, mag_fx, rad);
                ny = rescale(y, mag_fx, rad);
                x  = nx;
                y  = ny;
            end
        end
        if (x < -64) sdirs[0] = 1'b1;
        if (x > 64)  sdirs[1] = 1'b1;
        if (y < -64) sdirs[2] = 1'b1;
        if (y > 64)  sdirs[3] = 1'b1;
        // hat sectors in whole degrees
        if (hat != gac_pkg::HAT_CENTERED) begin
            deg = hat / 100;
            if (deg > 337 || deg < 23) py = -1;
            else if (deg < 68)  begin py = -1; px = 1;  end
            else if (deg < 113) px = 1;
            else if (deg < 158) begin py = 1;  px = 1;  end
            else if (deg < 203) py = 1;
            else if (deg < 248) begin py = 1;  px = -1; end
            else if (deg < 293) px = -1;
            else                begin py = -1; px = -1; end
        end
        if (px < 0) hdirs[0] = 1'b1;
        if (px > 0) hdirs[1] = 1'b1;
        if (py < 0) hdirs[2] = 1'b1;
        if (py > 0) hdirs[3] = 1'b1;
        if (ex < 64)  edirs[0] = 1'b1;
        if (ex > 192) edirs[1] = 1'b1;
        hx = 9'(px * 128);
        hy = 9'(py * 128);
        return {4'b0, edirs, 8'(ex), hdirs, hy, hx, sdirs, 8'(y), 8'(x)};
    endfunction

    function void note_sample(logic [63:0] raw, int unsigned rad);
        expected_q.push_back(condition(raw, rad));
    endfunction

    function void check_beat(logic [55:0] got);
        string names[8] = '{"stick_x", "stick_y", "stick_dirs", "hat_x",
                            "hat_y", "hat_dirs", "extra_pos", "extra_dirs"};
        int lsb[8] = '{0, 8, 16, 20, 29, 38, 42, 50};
        int wid[8] = '{8, 8, 4, 9, 9, 4, 8, 2};
        logic [55:0] exp_beat;
        logic [55:0] mask;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected output beat %h", got);
            return;
        end
        exp_beat = expected_q.pop_front();
        for (int f = 0; f < 8; f++) begin
            mask = ((56'd1 << wid[f]) - 1) << lsb[f];
            if ((got & mask) !== (exp_beat & mask)) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%s mismatch: expected %h got %h", names[f],
                             (exp_beat & mask) >> lsb[f], (got & mask) >> lsb[f]);
            end
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [6:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // raw_x, raw_y, raw_hat, raw_extra
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // stick_x, stick_y, stick_dirs, hat_x, hat_y,
                                 // hat_dirs, extra_pos, extra_dirs

    cond_scoreboard sb;
    int unsigned    radius;
    int             burst_left;
    int             stall_mode;

    gamepad_axis_conditioner_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #20ms;
        $display("** gamepad_axis_conditioner_top: FAILED **");
        $finish;
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata);
    end

    // receiver stall pattern, mode switched by the sender per phase
    always @(negedge i_clk) begin
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 15) < 8);
        endcase
    end

    // one sample beat, with random bursts and gaps around it
    task automatic send_sample(logic [63:0] raw);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_sample(raw, radius);
        @(negedge i_clk);
    endtask

    // drain, then write the deadzone radius
    task automatic write_radius(logic [6:0] val);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        radius = (val > gac_pkg::DZ_MAX) ? gac_pkg::DZ_MAX : val;
        stall_mode = $urandom_range(0, 3);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 9))
            0, 1: return 16'($urandom);
            2:    return 16'($signed($urandom_range(0, 20)) - 10);
            default: return 16'($signed($urandom_range(0, 280)) - 140);
        endcase
    endfunction

    function automatic logic [15:0] rand_hat();
        case ($urandom_range(0, 7))
            0: return gac_pkg::HAT_CENTERED;
            1: return 16'($urandom);
            2: return 16'($urandom_range(0, 8) * 4500 + $urandom_range(0, 200) - 100);
            default: return 16'($urandom_range(0, 35999));
        endcase
    endfunction

    function automatic logic [15:0] rand_extra();
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 40)) - 20);
            default: return 16'($urandom_range(0, 300));
        endcase
    endfunction

    task automatic random_phase(int count);
        repeat (count)
            send_sample({rand_extra(), rand_hat(), rand_axis(), rand_axis()});
    endtask

    initial begin
        logic [63:0] directed[$];
        sb = new();
        radius        = gac_pkg::DZ_RESET;
        burst_left    = 0;
        stall_mode    = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b1;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // field extremes, hat sector edges, centered hat, extra thresholds
        // {extra, hat, y, x}
        directed = '{
            {16'h8000, 16'hFFFF, 16'h8000, 16'h8000},
            {16'h7FFF, 16'd0,    16'h7FFF, 16'h7FFF},
            {16'hFFFF, 16'd2299, 16'hFF7F, 16'd128},
            {16'd0,    16'd2300, 16'd0,    16'd0},
            {16'd63,   16'd6799, 16'd5,    16'hFFF4},
            {16'd64,   16'd6800, 16'd19,   16'd0},
            {16'd192,  16'd11299, 16'd0,   16'd20},
            {16'd193,  16'd11300, 16'd65,  16'd64},
            {16'd255,  16'd15799, 16'hFFBF, 16'hFFC0},
            {16'd256,  16'd15800, 16'd127, 16'hFF80},
            {16'd100,  16'd20299, 16'd90,  16'd90},
            {16'd128,  16'd20300, 16'd14,  16'd13},
            {16'd1,    16'd24799, 16'hFF81, 16'd127},
            {16'd254,  16'd24800, 16'd40,  16'hFFD8},
            {16'd30,   16'd29299, 16'd0,   16'hFF80},
            {16'd200,  16'd29300, 16'h8000, 16'd0},
            {16'd50,   16'd33799, 16'd1,   16'd1},
            {16'd70,   16'd33800, 16'd100, 16'hFF9C},
            {16'd10,   16'd35999, 16'd66,  16'hFFBE},
            {16'd0,    16'd65534, 16'd3,   16'd127},
            {16'hFFC0, 16'hFFFE, 16'h7FFF, 16'h8000}
        };
        foreach (directed[i]) send_sample(directed[i]);
        random_phase(120);

        // deadzone off, the two largest settings, then assorted
        write_radius(7'd0);
        foreach (directed[i]) send_sample(directed[i]);
        random_phase(130);
        write_radius(7'd126);
        random_phase(110);
        write_radius(7'd127);
        random_phase(110);
        write_radius(7'd1);
        random_phase(120);
        write_radius(7'd64);
        random_phase(120);
        write_radius(7'($urandom_range(2, 125)));
        random_phase(120);
        write_radius(7'd19);
        random_phase(100);

        s_axis_tvalid <= 1'b0;
        stall_mode = 1;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("** gamepad_axis_conditioner_top: PASSED **");
        else
            $display("** gamepad_axis_conditioner_top: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/gac_pkg.sv
rtl/core/gac_sqrt_step.sv
rtl/core/gac_div_step.sv
rtl/core/gamepad_axis_conditioner_top.sv
tb/tb_top.sv
